// ===== design/deque_with_search_and_delete_macros.svh =====
// Assertion macros shared by the deque block.
// Both sample on clk and are disabled while rst_n is low.
`ifndef DEQUE_WITH_SEARCH_AND_DELETE_MACROS_SVH
`define DEQUE_WITH_SEARCH_AND_DELETE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DWSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define DWSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ===== design/dwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dwsd_pkg
// Shared types and constants of the deque with search and delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dwsd_pkg;

    localparam int DATA_W           = 32;
    localparam int FUNC_W           = 3;
    localparam int CAPACITY_DEFAULT = 64;

    // request codes; codes six and seven are unused
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_DELETE     = 3'd5
    } dwsd_func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } dwsd_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } dwsd_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
    } dwsd_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        dwsd_status_t             status;
    } dwsd_rsp_t;

endpackage

`default_nettype wire

// ===== design/dwsd_ram.sv =====
// ----------------------------------------------------------------------------
// dwsd_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwsd_ram
    import dwsd_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write and read the array, read data registered for the next cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/dwsd_obuf.sv =====
// ----------------------------------------------------------------------------
// dwsd_obuf
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwsd_obuf
    import dwsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire dwsd_rsp_t data,
    output logic           ready,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output dwsd_rsp_t      rsp
);

    logic      valid_reg;
    dwsd_rsp_t rsp_reg;

    // free when empty or when the held beat leaves this cycle
    assign ready = !valid_reg || !rsp_stall;

    // track the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // hold the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== design/dwsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwsd_ctrl
// Sequencer: ring pointers, request decode, scan and shift walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwsd_ctrl
    import dwsd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire dwsd_req_t                     req,
    output logic                               res_load,
    output dwsd_rsp_t                          res,
    input  wire logic                          res_ready,
    output logic                               mem_we,
    output logic [$clog2(CAPACITY)-1:0]        mem_waddr,
    output logic [DATA_W-1:0]                  mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(CAPACITY)-1:0]        mem_raddr,
    input  wire logic [DATA_W-1:0]             mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    dwsd_state_t       state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_pos_reg, rd_pos_next;
    logic [FUNC_W-1:0] op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    dwsd_status_t      res_status_reg, res_status_next;

    logic accept;
    logic empty;
    logic full;
    logic match;
    logic scan_last;
    logic is_delete;

    // ring slot of a list position, one compare and subtract
    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head_reg) + (CW+1)'(pos);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CAP_COUNT);
    assign match     = (mem_rdata == val_reg);
    assign scan_last = (rd_pos_reg == count_reg);
    assign is_delete = (dwsd_func_t'(op_reg) == FN_DELETE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (dwsd_func_t'(req.func))
                        FN_POP_FRONT, FN_POP_BACK:
                            state_next = empty ? ST_DONE : ST_POP_WAIT;
                        FN_SEARCH, FN_DELETE:
                            state_next = empty ? ST_DONE : ST_SCAN;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_POP_WAIT:
                state_next = ST_DONE;
            ST_SCAN:
            begin
                priority if (match && is_delete && !scan_last)
                    state_next = ST_SHIFT;
                else if (match || scan_last)
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN;
            end
            ST_SHIFT:
            begin
                if (scan_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath, memory access and result
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        rd_pos_next     = rd_pos_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_of(rd_pos_reg - CW'(2));
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = slot_of(rd_pos_reg);
        res_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.func;
                    val_next        = req.value;
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    unique case (dwsd_func_t'(req.func))
                        FN_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                head_next  = (head_reg == '0) ? LAST_SLOT
                                                              : head_reg - AW'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = head_next;
                                mem_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = slot_of(count_reg);
                                mem_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                head_next  = (head_reg == LAST_SLOT) ? '0
                                                                     : head_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_of(count_reg - CW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        FN_SEARCH, FN_DELETE:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_raddr   = head_reg;
                                rd_pos_next = CW'(1);
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_POP_WAIT:
            begin
                res_value_next = mem_rdata;
            end
            ST_SCAN:
            begin
                // compare the entry read last cycle; unless the scan ends here, fetch the next one
                priority if (match)
                begin
                    if (is_delete)
                    begin
                        res_value_next = mem_rdata;
                        if (scan_last)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            mem_re      = 1'b1;
                            rd_pos_next = rd_pos_reg + CW'(1);
                        end
                    end
                end
                else if (scan_last)
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    mem_re      = 1'b1;
                    rd_pos_next = rd_pos_reg + CW'(1);
                end
            end
            ST_SHIFT:
            begin
                // move the entry read last cycle one place toward the front
                mem_we = 1'b1;
                if (scan_last)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    mem_re      = 1'b1;
                    rd_pos_next = rd_pos_reg + CW'(1);
                end
            end
            ST_DONE:
            begin
                res_load = res_ready;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    assign res.result_value = res_value_reg;
    assign res.status       = res_status_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        rd_pos_reg     <= rd_pos_next;
        op_reg         <= op_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

endmodule

`default_nettype wire

// ===== design/deque_with_search_and_delete.sv =====
// Deque of signed 32-bit values with search and delete by value.
// Request channel (req_valid, req_stall, req): one beat carries func and value.
// Result channel (rsp_valid, rsp_stall, rsp): one beat per request, in order,
// with the popped or deleted value and a status code.
// Requests are taken one at a time; req_stall is high from the cycle after
// an accept until the result has moved into the output register.
// Each request walks the sequencer states: push, unused codes and any failed
// empty/full check go straight to the done state; pop waits for the read
// data; search scans from the front (position 0) until a match or the end
// of the list; delete scans and then shifts the later entries, since the
// scan and the shift of later entries together touch every live entry once
// through the single read port.
// The next request is accepted the cycle after its result is loaded.
// While rsp_stall holds the result, the finished request waits in its final
// state and req_stall stays high.
// Reset empties the list (head and count cleared); entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "deque_with_search_and_delete_macros.svh"

module deque_with_search_and_delete
    import dwsd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire dwsd_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output dwsd_rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic              res_load;
    logic              res_ready;
    dwsd_rsp_t         res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // sequencer
    dwsd_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_load  (res_load),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // entry store
    dwsd_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result register
    dwsd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .data      (res),
        .ready     (res_ready),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // an accepted request keeps the block busy in the next cycle
    `DWSD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

    // a result is loaded only into a free output register
    `DWSD_ASSERT_NOW(a_load_when_free, res_load, res_ready)

    // a result belongs to a request in flight
    `DWSD_ASSERT_NOW(a_load_while_busy, res_load, req_stall)

    // a delivered beat with nothing behind it leaves the output empty
    `DWSD_ASSERT_NEXT(a_drain_output, rsp_valid && !rsp_stall && !res_load, !rsp_valid)

endmodule

`default_nettype wire
